// ===== src/swpp_pkg.sv =====
package swpp_pkg;

   // window depth and field widths
   localparam int MAX_WINDOW = 64;
   localparam int SAMPLE_W   = 16;
   localparam int WL_W       = 7;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int CMP_W      = (CNT_W > WL_W) ? CNT_W : WL_W;

   // scan token handed from cell to cell
   typedef struct packed {
      logic                       active;
      logic [CNT_W-1:0]           count;
      logic signed [SAMPLE_W-1:0] hi;
      logic signed [SAMPLE_W-1:0] lo;
   } swpp_tok_type;

endpackage

// ===== src/swpp_cell.sv =====
module swpp_cell (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  logic                               clear,
   input  logic signed [swpp_pkg::SAMPLE_W-1:0] sample_in,
   input  logic                               valid_in,
   output logic signed [swpp_pkg::SAMPLE_W-1:0] sample_out,
   output logic                               valid_out,
   input  swpp_pkg::swpp_tok_type             tok_in,
   output swpp_pkg::swpp_tok_type             tok_out
);
   import swpp_pkg::*;

   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       valid_ff;
   logic                       valid_in_nxt;
   swpp_tok_type               tok_ff;
   swpp_tok_type               tok_in_nxt;
   logic                       take;

   // history shift: newest sample enters at the head of the row
   always_ff @(posedge clock) begin
      if (shift_en) begin
         sample_ff <= sample_in;
      end
   end

   // fill marker, cleared on restart in every cell but the head
   always_comb begin
      valid_in_nxt = valid_ff;
      if (shift_en) begin
         valid_in_nxt = clear ? 1'b0 : valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in_nxt;
      end
   end

   // fold this cell's sample into the passing token while samples remain
   assign take = (tok_in.count != '0) && valid_ff;

   always_comb begin
      tok_in_nxt = tok_in;
      if (take) begin
         tok_in_nxt.count = tok_in.count - CNT_W'(1);
         if (sample_ff > tok_in.hi) begin
            tok_in_nxt.hi = sample_ff;
         end
         if (sample_ff < tok_in.lo) begin
            tok_in_nxt.lo = sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.active <= 1'b0;
      end else begin
         tok_ff.active <= tok_in_nxt.active;
      end
      tok_ff.count <= tok_in_nxt.count;
      tok_ff.hi    <= tok_in_nxt.hi;
      tok_ff.lo    <= tok_in_nxt.lo;
   end

   assign sample_out = sample_ff;
   assign valid_out  = valid_ff;
   assign tok_out    = tok_ff;

endmodule

// ===== src/sliding_window_peak_to_peak_top.sv =====
// channel | ports              | payload
// request | req_t*             | tdata[15:0] sample, tuser restart
// result  | rsp_t*             | tdata[15:0] window_range, tdata[31:16] best_range
// csr     | csr_we, csr_wdata  | window_length (7 bits)
//
// one request at a time: the sample shifts into a row of MAX_WINDOW cells and a
// scan token walks the row one cell a clock; the range then passes the holding
// stage and the output register, and no new request is taken while a scan runs.
// the next request is taken once the result has left the holding stage, even
// while it still waits on rsp_tready (one holding stage in between).
// reset is synchronous and clears the history markers, best range and csr (1).
module sliding_window_peak_to_peak_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] sample
   input  logic        req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] window_range, [31:16] best_range
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata    // [6:0] window_length
);
   import swpp_pkg::*;

   logic [WL_W-1:0]            wl_ff;
   logic                       busy_ff;
   logic                       busy_in;
   logic                       start_ff;
   logic                       restart_ff;
   logic                       pend_valid_ff;
   logic                       pend_valid_in;
   logic                       pend_restart_ff;
   logic [SAMPLE_W-1:0]        pend_range_ff;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_range_ff;
   logic [SAMPLE_W-1:0]        best_ff;
   logic [SAMPLE_W-1:0]        best_in;
   logic [SAMPLE_W-1:0]        best_base;
   logic                       accept;
   logic                       done;
   logic                       move;
   logic [CMP_W-1:0]           wl_ext;
   logic [CNT_W-1:0]           len_eff;
   logic [SAMPLE_W:0]          diff;
   swpp_tok_type               head_tok;

   logic signed [SAMPLE_W-1:0] smp_chain [0:MAX_WINDOW];
   logic                       vld_chain [0:MAX_WINDOW];
   swpp_tok_type               tok_chain [0:MAX_WINDOW];

   assign accept = req_tvalid && req_tready;
   assign req_tready = !busy_ff && !pend_valid_ff;

   // window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         wl_ff <= WL_W'(1);
      end else if (csr_we) begin
         wl_ff <= csr_wdata;
      end
   end

   // effective length: zero acts as one, beyond the depth acts as the depth
   assign wl_ext = CMP_W'(wl_ff);
   always_comb begin
      priority if (wl_ext == '0) begin
         len_eff = CNT_W'(1);
      end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
         len_eff = CNT_W'(MAX_WINDOW);
      end else begin
         len_eff = CNT_W'(wl_ext);
      end
   end

   // token injected in the cycle after the sample has shifted in
   always_comb begin
      head_tok.active = start_ff;
      head_tok.count  = len_eff;
      head_tok.hi     = {1'b1, {(SAMPLE_W-1){1'b0}}};
      head_tok.lo     = {1'b0, {(SAMPLE_W-1){1'b1}}};
   end

   assign smp_chain[0] = req_tdata;
   assign vld_chain[0] = 1'b1;
   assign tok_chain[0] = head_tok;

   // row of cells; a restart drops the older samples, the new one at the head stays
   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      swpp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .clear      (req_tuser && (g != 0)),
         .sample_in  (smp_chain[g]),
         .valid_in   (vld_chain[g]),
         .sample_out (smp_chain[g+1]),
         .valid_out  (vld_chain[g+1]),
         .tok_in     (tok_chain[g]),
         .tok_out    (tok_chain[g+1])
      );
   end

   assign done = tok_chain[MAX_WINDOW].active;
   assign move = pend_valid_ff && (!rsp_valid_ff || rsp_tready);

   // request tracking
   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         start_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         start_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         restart_ff <= req_tuser;
      end
   end

   // range of the finished scan into the holding stage
   assign diff = {tok_chain[MAX_WINDOW].hi[SAMPLE_W-1], tok_chain[MAX_WINDOW].hi}
               - {tok_chain[MAX_WINDOW].lo[SAMPLE_W-1], tok_chain[MAX_WINDOW].lo};

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (done) begin
         pend_valid_in = 1'b1;
      end else if (move) begin
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         pend_range_ff   <= diff[SAMPLE_W-1:0];
         pend_restart_ff <= restart_ff;
      end
   end

   // best range, restarted from zero when the request asked for it
   assign best_base = pend_restart_ff ? '0 : best_ff;
   assign best_in   = (pend_range_ff > best_base) ? pend_range_ff : best_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else if (move) begin
         best_ff <= best_in;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         rsp_range_ff <= pend_range_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {best_ff, rsp_range_ff};

endmodule

// ===== src/swpp_checker.sv =====
module swpp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a stalled result holds its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // best range never falls below the window range it reports with
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] >= rsp_tdata[15:0])
      else $error("best range below window range");

   // one request at a time: no request taken in the cycle after one
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while scan busy");

   // no result straight after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result shown after reset");

   // a request taken while no result shows is not followed by an early result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("result appeared too early");

endmodule

bind sliding_window_peak_to_peak_top swpp_checker u_swpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
